// File: rtl/core/rrhb_pkg.sv
// shared types and constants for the recency row history buffer
`default_nettype none
package rrhb_pkg;
	localparam int MaxRows = 16;
	localparam int MaxCols = 64;
	localparam int SlotW = $clog2(MaxRows);
	localparam int ColW = $clog2(MaxCols);
	localparam int AddrW = SlotW + ColW;
	localparam int CntW = $clog2(MaxRows + 1);
	localparam int RwW = $clog2(MaxCols + 1);
	localparam int QDepth = 2;
	localparam int QIdxW = 1;

	localparam logic [CntW-1:0] RowsReset = CntW'(MaxRows < 16 ? MaxRows : 16);
	localparam logic [RwW-1:0] ColsReset = RwW'(MaxCols < 64 ? MaxCols : 64);

	typedef enum logic [2:0] {
		OP_WR_NEW = 3'd0,
		OP_WR_TOP = 3'd1,
		OP_READ = 3'd2,
		OP_DELETE = 3'd3,
		OP_CLR_RANGE = 3'd4,
		OP_CLR_ALL = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_INVALID = 2'd1,
		ST_NO_SPACE = 2'd2
	} status_t;

	localparam logic REG_ROWS_IN_USE = 1'b0;
	localparam logic REG_ROW_WORDS = 1'b1;

	typedef enum logic [1:0] {
		CMD_NONE = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_READ = 2'd2,
		CMD_ZERO = 2'd3
	} cmd_t;

	// classified item handed from front to back
	typedef struct packed {
		cmd_t cmd;
		logic [SlotW-1:0] slot;
		logic [ColW-1:0] col;
		logic [31:0] data;
		status_t status;
		logic [CntW-1:0] rows_held;
	} job_t;
endpackage
`default_nettype wire

// File: rtl/core/rrhb_front.sv
// front: order table, row count, registers and item classification
`default_nettype none
module rrhb_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [2:0] op,
	input wire logic [3:0] row_index,
	input wire logic [5:0] col_index,
	input wire logic [31:0] word,
	input wire logic start_row,
	input wire logic [4:0] range_count,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [0:0] cfg_index,
	input wire logic [6:0] cfg_data,
	input wire logic q_full,
	output logic job_push,
	output rrhb_pkg::job_t job
);
	localparam int SW = rrhb_pkg::SlotW;
	localparam int CW = rrhb_pkg::CntW;

	logic [SW-1:0] order_q [rrhb_pkg::MaxRows];
	logic [SW-1:0] order_d [rrhb_pkg::MaxRows];
	logic [CW-1:0] valid_q, valid_d;
	logic [CW-1:0] rows_q;
	logic [rrhb_pkg::RwW-1:0] cols_q;
	logic accept;
	logic col_ok;
	logic [CW:0] rend;
	logic [CW-1:0] first, cnt;
	logic do_move;

	assign in_stall = q_full;
	assign cfg_ready = 1'b1;
	assign accept = in_valid && !q_full;
	assign col_ok = {1'b0, col_index} < cols_q;
	assign rend = {1'b0, CW'(row_index)} + {1'b0, range_count};

	always_comb begin
		order_d = order_q;
		valid_d = valid_q;
		do_move = 1'b0;
		first = CW'(row_index);
		cnt = range_count;
		job.cmd = rrhb_pkg::CMD_NONE;
		job.slot = order_q[0];
		job.col = col_index;
		job.data = word;
		job.status = rrhb_pkg::ST_OK;
		case (op)
			rrhb_pkg::OP_WR_NEW, rrhb_pkg::OP_WR_TOP: begin
				if (!col_ok) begin
					job.status = rrhb_pkg::ST_NO_SPACE;
				end else begin
					job.cmd = rrhb_pkg::CMD_WRITE;
					if (op == rrhb_pkg::OP_WR_NEW && start_row) begin
						order_d[0] = order_q[SW'(rows_q - 1'b1)];
						for (int p = 1; p < rrhb_pkg::MaxRows; p++) begin
							if (p < rows_q) order_d[p] = order_q[p-1];
						end
						job.slot = order_q[SW'(rows_q - 1'b1)];
						if (valid_q < rows_q) valid_d = valid_q + 1'b1;
					end
				end
			end
			rrhb_pkg::OP_READ: begin
				job.slot = order_q[row_index];
				if (CW'(row_index) >= valid_q || !col_ok) job.status = rrhb_pkg::ST_INVALID;
				else job.cmd = rrhb_pkg::CMD_READ;
			end
			rrhb_pkg::OP_DELETE: begin
				job.slot = order_q[row_index];
				if (CW'(row_index) >= valid_q) begin
					job.status = rrhb_pkg::ST_INVALID;
				end else begin
					job.cmd = rrhb_pkg::CMD_ZERO;
					valid_d = valid_q - 1'b1;
					do_move = 1'b1;
					cnt = CW'(1);
				end
			end
			rrhb_pkg::OP_CLR_RANGE: begin
				if (range_count == '0 || rend > {1'b0, valid_q}) begin
					job.status = rrhb_pkg::ST_INVALID;
				end else begin
					valid_d = valid_q - range_count;
					do_move = 1'b1;
				end
			end
			rrhb_pkg::OP_CLR_ALL: valid_d = '0;
			default: job.status = rrhb_pkg::ST_INVALID;
		endcase
		if (do_move) begin
			for (int p = 0; p < rrhb_pkg::MaxRows; p++) begin
				if (p < rows_q && p >= first) begin
					if (p < rows_q - cnt) order_d[p] = order_q[SW'(p + cnt)];
					else order_d[p] = order_q[SW'(p - (rows_q - cnt) + first)];
				end
			end
		end
		job.rows_held = valid_d;
	end

	assign job_push = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rrhb_pkg::MaxRows; i++) order_q[i] <= SW'(i);
			valid_q <= '0;
			rows_q <= rrhb_pkg::RowsReset;
			cols_q <= rrhb_pkg::ColsReset;
		end else begin
			if (accept) begin
				order_q <= order_d;
				valid_q <= valid_d;
			end
			if (cfg_valid) begin
				if (cfg_index == rrhb_pkg::REG_ROWS_IN_USE) begin
					if (cfg_data > 7'(rows_q) && cfg_data <= 7'(rrhb_pkg::MaxRows))
						rows_q <= CW'(cfg_data);
				end else begin
					if (cfg_data != '0 && cfg_data <= 7'(rrhb_pkg::MaxCols))
						cols_q <= rrhb_pkg::RwW'(cfg_data);
				end
			end
		end
	end

	a_valid_le_rows: assert property (@(posedge clk) disable iff (!arst_n) valid_q <= rows_q)
		else $error("row count above slot count");
	a_rows_grow: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> rows_q >= $past(rows_q))
		else $error("slot count shrank");
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n) in_stall == q_full)
		else $error("stall mismatch");
endmodule
`default_nettype wire

// File: rtl/core/rrhb_back.sv
// back: job queue, row memory with zeroing sweep, result register
`default_nettype none
module rrhb_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic job_push,
	input wire rrhb_pkg::job_t job,
	output logic q_full,
	output logic out_valid,
	input wire logic out_stall,
	output logic [31:0] read_word,
	output logic [1:0] status,
	output logic [4:0] rows_held
);
	localparam int CW = rrhb_pkg::ColW;

	rrhb_pkg::job_t q_q [rrhb_pkg::QDepth];
	logic [rrhb_pkg::QIdxW-1:0] wp_q, rp_q;
	logic [rrhb_pkg::QIdxW:0] n_q;
	rrhb_pkg::job_t cur;
	logic [31:0] mem_q [rrhb_pkg::MaxRows*rrhb_pkg::MaxCols];
	logic [31:0] rdata_q;
	logic [CW:0] zc_q;
	logic busy_q;
	logic pend_q;
	logic clearing_q;
	logic [rrhb_pkg::AddrW-1:0] clr_q;
	rrhb_pkg::job_t pend_s1;
	logic pop, done, out_free;

	assign cur = q_q[rp_q];
	// hold off new words while the memory is cleared after reset or the job queue is full
	assign q_full = clearing_q || n_q == (rrhb_pkg::QIdxW+1)'(rrhb_pkg::QDepth);
	assign done = (CW+1)'(zc_q) == (CW+1)'(rrhb_pkg::MaxCols - 1);
	assign out_free = !out_valid || !out_stall;
	// a job issues when the result stage is free; zero jobs issue on the last sweep step
	assign pop = n_q != '0 && !pend_q && out_free
		&& (cur.cmd != rrhb_pkg::CMD_ZERO || (busy_q && done));

	always_ff @(posedge clk) begin
		if (job_push) q_q[wp_q] <= job;
		if (clearing_q) begin
			mem_q[clr_q] <= '0;
		end else if (n_q != '0 && !pend_q && out_free) begin
			if (cur.cmd == rrhb_pkg::CMD_WRITE) mem_q[{cur.slot, cur.col}] <= cur.data;
			else if (cur.cmd == rrhb_pkg::CMD_ZERO && busy_q)
				mem_q[{cur.slot, CW'(zc_q)}] <= '0;
		end
		rdata_q <= mem_q[{cur.slot, cur.col}];
		if (pop) pend_s1 <= cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			n_q <= '0;
			zc_q <= '0;
			busy_q <= 1'b0;
			pend_q <= 1'b0;
			clearing_q <= 1'b1;
			clr_q <= '0;
			out_valid <= 1'b0;
			read_word <= '0;
			status <= '0;
			rows_held <= '0;
		end else begin
			if (clearing_q) begin
				clr_q <= clr_q + 1'b1;
				if (&clr_q) clearing_q <= 1'b0;
			end
			if (job_push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			n_q <= n_q + (job_push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
			if (n_q != '0 && cur.cmd == rrhb_pkg::CMD_ZERO && !pend_q && out_free) begin
				if (!busy_q) begin
					busy_q <= 1'b1;
					zc_q <= '0;
				end else if (done) begin
					busy_q <= 1'b0;
					zc_q <= '0;
				end else begin
					zc_q <= zc_q + 1'b1;
				end
			end
			if (out_valid && !out_stall) out_valid <= 1'b0;
			pend_q <= pop;
			if (pend_q) begin
				out_valid <= 1'b1;
				read_word <= pend_s1.cmd == rrhb_pkg::CMD_READ ? rdata_q : '0;
				status <= pend_s1.status;
				rows_held <= 5'(pend_s1.rows_held);
			end
		end
	end

	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= (rrhb_pkg::QIdxW+1)'(rrhb_pkg::QDepth))
		else $error("queue overflow");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(job_push && q_full && !pop))
		else $error("push into full queue");
	a_zero_busy: assert property (@(posedge clk) disable iff (!arst_n) zc_q != '0 |-> busy_q)
		else $error("sweep counter without sweep");
endmodule
`default_nettype wire

// File: rtl/core/recency_row_history_buffer.sv
// top level of the recency row history buffer
// writes, reads and clears pass from the job queue through a pending stage into the result register
// delete also runs a zeroing sweep of the row's 64 words on the row memory port
// a new job issues only when no earlier job is pending; the job queue takes words meanwhile
// reset: order table identity, no valid rows, 16 rows in use, 64 words per row
// after reset a clearing pass zeroes all 1024 words of the row memory while input is stalled
`default_nettype none
module recency_row_history_buffer (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [2:0] op,
	input wire logic [3:0] row_index,
	input wire logic [5:0] col_index,
	input wire logic [31:0] word,
	input wire logic start_row,
	input wire logic [4:0] range_count,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [0:0] cfg_index,
	input wire logic [6:0] cfg_data,
	output logic out_valid,
	input wire logic out_stall,
	output logic [31:0] read_word,
	output logic [1:0] status,
	output logic [4:0] rows_held
);
	logic q_full, job_push;
	rrhb_pkg::job_t job;

	rrhb_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .op, .row_index, .col_index, .word,
		.start_row, .range_count, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.q_full, .job_push, .job
	);

	rrhb_back u_back (
		.clk, .arst_n, .job_push, .job, .q_full, .out_valid, .out_stall,
		.read_word, .status, .rows_held
	);
endmodule
`default_nettype wire

// File: verif/tb.sv
// self-checking testbench for the recency row history buffer
`timescale 1ns / 100ps
module tb;
	localparam logic [2:0] OP_SPARE_A = 3'd6;
	localparam logic [2:0] OP_SPARE_B = 3'd7;
	localparam int CycleLimit = 1000000;
	localparam int DrainCycles = 80;

	typedef struct {
		logic [31:0] rd;
		logic [1:0] st;
		logic [4:0] held;
	} result_t;

	typedef struct {
		logic [2:0] op;
		logic [3:0] row;
		logic [5:0] col;
		logic [31:0] w;
		logic s;
		logic [4:0] cnt;
		bit typed;
		logic [31:0] rd;
		logic [1:0] st;
		logic [4:0] held;
	} dir_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] op = '0;
	logic [3:0] row_index = '0;
	logic [5:0] col_index = '0;
	logic [31:0] word = '0;
	logic start_row = 1'b0;
	logic [4:0] range_count = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [0:0] cfg_index = '0;
	logic [6:0] cfg_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [31:0] read_word;
	logic [1:0] status;
	logic [4:0] rows_held;

	recency_row_history_buffer dut (.*);

	always #5 clk = ~clk;

	// shadow state of the history
	logic [3:0] order_map [rrhb_pkg::MaxRows];
	logic [31:0] row_mem [rrhb_pkg::MaxRows][rrhb_pkg::MaxCols];
	int held_rows;
	int rows_use;
	int words_per_row;

	result_t pending_results [$];
	int words_taken = 0;
	int cfg_taken = 0;
	int errors = 0;
	int cycles = 0;
	bit calm = 1'b0;
	bit cur_typed = 1'b0;
	result_t cur_result;

	dir_item_t dir_tab [20] = '{
		'{rrhb_pkg::OP_READ, 0, 0, 0, 0, 0, 1, 0, rrhb_pkg::ST_INVALID, 0},
		'{rrhb_pkg::OP_WR_TOP, 0, 0, 32'hFFFFFFFF, 0, 0, 1, 0, rrhb_pkg::ST_OK, 0},
		'{rrhb_pkg::OP_WR_NEW, 0, 63, 0, 1, 0, 1, 0, rrhb_pkg::ST_OK, 1},
		'{rrhb_pkg::OP_WR_NEW, 0, 0, 32'hA5A5A5A5, 1, 0, 1, 0, rrhb_pkg::ST_OK, 2},
		'{rrhb_pkg::OP_WR_NEW, 0, 1, 32'h5A5A5A5A, 0, 0, 0, 0, 0, 0},
		'{rrhb_pkg::OP_WR_TOP, 0, 63, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0},
		'{rrhb_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{rrhb_pkg::OP_READ, 1, 63, 0, 0, 0, 0, 0, 0, 0},
		'{rrhb_pkg::OP_READ, 2, 0, 0, 0, 0, 1, 0, rrhb_pkg::ST_INVALID, 2},
		'{OP_SPARE_A, 0, 0, 0, 0, 0, 1, 0, rrhb_pkg::ST_INVALID, 2},
		'{OP_SPARE_B, 15, 63, 32'hFFFFFFFF, 1, 31, 1, 0, rrhb_pkg::ST_INVALID, 2},
		'{rrhb_pkg::OP_CLR_RANGE, 0, 0, 0, 0, 0, 1, 0, rrhb_pkg::ST_INVALID, 2},
		'{rrhb_pkg::OP_CLR_RANGE, 1, 0, 0, 0, 16, 1, 0, rrhb_pkg::ST_INVALID, 2},
		'{rrhb_pkg::OP_DELETE, 15, 0, 0, 0, 0, 1, 0, rrhb_pkg::ST_INVALID, 2},
		'{rrhb_pkg::OP_DELETE, 0, 0, 0, 0, 0, 1, 0, rrhb_pkg::ST_OK, 1},
		'{rrhb_pkg::OP_READ, 0, 63, 0, 0, 0, 0, 0, 0, 0},
		'{rrhb_pkg::OP_CLR_RANGE, 0, 0, 0, 0, 1, 1, 0, rrhb_pkg::ST_OK, 0},
		'{rrhb_pkg::OP_WR_NEW, 0, 5, 32'h00000001, 1, 0, 1, 0, rrhb_pkg::ST_OK, 1},
		'{rrhb_pkg::OP_CLR_ALL, 0, 0, 0, 0, 0, 1, 0, rrhb_pkg::ST_OK, 0},
		'{rrhb_pkg::OP_READ, 0, 0, 0, 0, 0, 1, 0, rrhb_pkg::ST_INVALID, 0}
	};

	function automatic void move_last(int first, int count);
		logic [3:0] tmp [rrhb_pkg::MaxRows];
		int n;
		n = 0;
		for (int p = 0; p < first; p++) tmp[n++] = order_map[p];
		for (int p = first + count; p < rows_use; p++) tmp[n++] = order_map[p];
		for (int p = first; p < first + count; p++) tmp[n++] = order_map[p];
		for (int p = 0; p < rows_use; p++) order_map[p] = tmp[p];
	endfunction

	function automatic result_t history_step(logic [2:0] o, int r, int c, logic [31:0] w,
			logic s, int cnt);
		result_t e;
		logic [3:0] last;
		e.rd = '0;
		e.st = rrhb_pkg::ST_OK;
		case (o)
			rrhb_pkg::OP_WR_NEW, rrhb_pkg::OP_WR_TOP: begin
				if (c >= words_per_row) begin
					e.st = rrhb_pkg::ST_NO_SPACE;
				end else begin
					if (o == rrhb_pkg::OP_WR_NEW && s) begin
						last = order_map[rows_use - 1];
						for (int p = rows_use - 1; p > 0; p--) order_map[p] = order_map[p - 1];
						order_map[0] = last;
						if (held_rows < rows_use) held_rows++;
					end
					row_mem[order_map[0]][c] = w;
				end
			end
			rrhb_pkg::OP_READ: begin
				if (r >= held_rows || c >= words_per_row) e.st = rrhb_pkg::ST_INVALID;
				else e.rd = row_mem[order_map[r]][c];
			end
			rrhb_pkg::OP_DELETE: begin
				if (r >= held_rows) begin
					e.st = rrhb_pkg::ST_INVALID;
				end else begin
					for (int k = 0; k < rrhb_pkg::MaxCols; k++) row_mem[order_map[r]][k] = '0;
					held_rows--;
					move_last(r, 1);
				end
			end
			rrhb_pkg::OP_CLR_RANGE: begin
				if (cnt == 0 || r + cnt > held_rows) begin
					e.st = rrhb_pkg::ST_INVALID;
				end else begin
					held_rows -= cnt;
					move_last(r, cnt);
				end
			end
			rrhb_pkg::OP_CLR_ALL: held_rows = 0;
			default: e.st = rrhb_pkg::ST_INVALID;
		endcase
		e.held = 5'(held_rows);
		return e;
	endfunction

	initial begin
		for (int i = 0; i < rrhb_pkg::MaxRows; i++) begin
			order_map[i] = 4'(i);
			for (int k = 0; k < rrhb_pkg::MaxCols; k++) row_mem[i][k] = '0;
		end
		held_rows = 0;
		rows_use = rrhb_pkg::RowsReset;
		words_per_row = rrhb_pkg::ColsReset;
	end

	always @(posedge clk) begin
		result_t e, got;
		cycles++;
		if (cycles > CycleLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
		if (in_valid && !in_stall) begin
			e = history_step(op, row_index, col_index, word, start_row, range_count);
			if (cur_typed) e = cur_result;
			pending_results.push_back(e);
			words_taken++;
		end
		if (cfg_valid && cfg_ready) begin
			if (cfg_index == rrhb_pkg::REG_ROWS_IN_USE) begin
				if (cfg_data > rows_use && cfg_data <= rrhb_pkg::MaxRows) rows_use = cfg_data;
			end else begin
				if (cfg_data >= 1 && cfg_data <= rrhb_pkg::MaxCols) words_per_row = cfg_data;
			end
			cfg_taken++;
		end
		if (out_valid && !out_stall) begin
			got.rd = read_word;
			got.st = status;
			got.held = rows_held;
			if (pending_results.size() == 0) begin
				$display("%0t: result with none expected: rd %h st %0d held %0d",
					$time, read_word, status, rows_held);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (got.rd !== e.rd) begin
					$display("%0t: read_word exp %h got %h", $time, e.rd, got.rd);
					errors++;
				end
				if (got.st !== e.st) begin
					$display("%0t: status exp %0d got %0d", $time, e.st, got.st);
					errors++;
				end
				if (got.held !== e.held) begin
					$display("%0t: rows_held exp %0d got %0d", $time, e.held, got.held);
					errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		out_stall = calm ? 1'b0 : ($urandom_range(0, 99) < 35);
	end

	task automatic send_word(logic [2:0] o, logic [3:0] r, logic [5:0] c, logic [31:0] w,
			logic s, logic [4:0] cnt);
		int prev;
		while (!calm && $urandom_range(0, 99) < 35) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		op = o;
		row_index = r;
		col_index = c;
		word = w;
		start_row = s;
		range_count = cnt;
		in_valid = 1'b1;
		prev = words_taken;
		do @(negedge clk); while (words_taken == prev);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [6:0] val);
		int prev;
		in_valid = 1'b0;
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1'b1;
		prev = cfg_taken;
		do @(negedge clk); while (cfg_taken == prev);
		cfg_valid = 1'b0;
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (DrainCycles) @(negedge clk);
	endtask

	task automatic random_word();
		logic [2:0] o;
		int r, c, cnt, pick;
		logic s;
		o = 3'($urandom_range(0, 7));
		r = $urandom_range(0, 15);
		c = $urandom_range(0, 63);
		s = 1'($urandom);
		cnt = $urandom_range(0, 16);
		pick = $urandom_range(0, 99);
		if (pick < 18) begin
			o = rrhb_pkg::OP_WR_NEW;
			s = 1'b1;
			c = $urandom_range(0, words_per_row - 1);
		end else if (pick < 43) begin
			o = s ? rrhb_pkg::OP_WR_TOP : rrhb_pkg::OP_WR_NEW;
			s = 1'b0;
			c = $urandom_range(0, words_per_row - 1);
		end else if (pick < 68 && held_rows > 0) begin
			o = rrhb_pkg::OP_READ;
			r = $urandom_range(0, held_rows - 1);
			c = $urandom_range(0, words_per_row - 1);
		end else if (pick < 73 && held_rows > 0) begin
			o = rrhb_pkg::OP_DELETE;
			r = $urandom_range(0, held_rows - 1);
		end else if (pick < 78 && held_rows > 0) begin
			o = rrhb_pkg::OP_CLR_RANGE;
			r = $urandom_range(0, held_rows - 1);
			cnt = $urandom_range(1, held_rows - r);
		end else if (pick < 80) begin
			o = rrhb_pkg::OP_CLR_ALL;
		end
		send_word(o, 4'(r), 6'(c), $urandom, s, 5'(cnt));
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (dir_tab[i]) begin
			cur_typed = dir_tab[i].typed;
			cur_result.rd = dir_tab[i].rd;
			cur_result.st = dir_tab[i].st;
			cur_result.held = dir_tab[i].held;
			send_word(dir_tab[i].op, dir_tab[i].row, dir_tab[i].col, dir_tab[i].w,
				dir_tab[i].s, dir_tab[i].cnt);
		end
		cur_typed = 1'b0;
		for (int ph = 0; ph < 5; ph++) begin
			drain();
			case (ph)
				0: begin
					write_reg(rrhb_pkg::REG_ROWS_IN_USE, 7'd8);
					write_reg(rrhb_pkg::REG_ROW_WORDS, 7'd8);
				end
				1: begin
					write_reg(rrhb_pkg::REG_ROW_WORDS, 7'd1);
					write_reg(rrhb_pkg::REG_ROWS_IN_USE, 7'd17);
				end
				2: begin
					write_reg(rrhb_pkg::REG_ROW_WORDS, 7'd64);
					write_reg(rrhb_pkg::REG_ROWS_IN_USE, 7'd16);
				end
				3: begin
					write_reg(rrhb_pkg::REG_ROW_WORDS, 7'd0);
					write_reg(rrhb_pkg::REG_ROW_WORDS, 7'd5);
				end
				default: begin
					write_reg(rrhb_pkg::REG_ROW_WORDS, 7'd100);
					write_reg(rrhb_pkg::REG_ROWS_IN_USE, 7'd1);
				end
			endcase
			for (int n = 0; n < 226; n++) begin
				calm = (ph == 2 && n >= 40 && n < 160);
				random_word();
			end
			calm = 1'b0;
		end
		drain();
		if (errors == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
